@@ rtl/core/maa_pkg.sv @@
// ----------------------------------------------------------------------------
// maa_pkg
// Shared constants, arctangent table and item types of the axis angle block.
// ----------------------------------------------------------------------------
package maa_pkg;

   localparam int AXIS_W         = 16;
   localparam int ANGLE_W        = 15;
   localparam int ANGLE_FRAC_DEF = 6;

   // cordic format: angle accumulator in 2^-20 degree, operands scaled by 2^30
   localparam int ACC_FRAC    = 20;
   localparam int ITERS       = 24;
   localparam int PRESCALE    = 30;
   localparam int OP_W        = AXIS_W + 1;
   localparam int XY_W        = OP_W + PRESCALE + 2;
   localparam int Z_W         = 32;
   localparam int LANE_STAGES = ITERS + 2;

   localparam int REQ_W     = 48;
   localparam int RSP_W     = 96;
   localparam int RSP_PAD_W = RSP_W - 3 * AXIS_W - 3 * ANGLE_W;

   localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180 << ACC_FRAC);
   localparam logic signed [Z_W-1:0] NEG_HALF_TURN = -HALF_TURN;

   // atan(2^-i) in 2^-20 degree, rounded to nearest
   localparam logic signed [Z_W-1:0] ATAN_TAB [ITERS] = '{
      32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
      32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
      32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
      32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
      32'sd917,      32'sd458,      32'sd229,      32'sd115,
      32'sd57,       32'sd29,       32'sd14,       32'sd7
   };

   typedef struct packed {
      logic signed [AXIS_W-1:0] x_value;
      logic signed [AXIS_W-1:0] y_value;
      logic signed [AXIS_W-1:0] z_value;
   } axes_type;

   // packed so that x_value sits in the lowest bits of tdata
   typedef struct packed {
      logic [RSP_PAD_W-1:0]     pad;
      logic [ANGLE_W-1:0]       angle_zy_plane;
      logic [ANGLE_W-1:0]       angle_zx_plane;
      logic [ANGLE_W-1:0]       angle_xy_plane;
      logic signed [AXIS_W-1:0] z_value;
      logic signed [AXIS_W-1:0] y_value;
      logic signed [AXIS_W-1:0] x_value;
   } result_type;

endpackage

@@ rtl/core/maa_cordic_lane.sv @@
// ----------------------------------------------------------------------------
// maa_cordic_lane
// Pipelined vectoring cordic: atan2(ordinate, abscissa) + 180 degrees.
// ----------------------------------------------------------------------------
module maa_cordic_lane
   import maa_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [AXIS_W-1:0] ordinate,
   input  logic signed [AXIS_W-1:0] abscissa,
   output logic [ANGLE_W-1:0]       angle
);

   localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] RND_OFFSET = Z_W'(HALF_TURN + (1 << (SH - 1)));
   localparam logic [ANGLE_W-1:0] FULL_CODE = ANGLE_W'(360 << ANGLE_FRAC_BITS);
   localparam logic [ANGLE_W-1:0] ZERO_CODE = ANGLE_W'(180 << ANGLE_FRAC_BITS);

   logic signed [XY_W-1:0] x_ff [ITERS+1];
   logic signed [XY_W-1:0] y_ff [ITERS+1];
   logic signed [Z_W-1:0]  z_ff [ITERS+1];
   logic                   zero_ff [ITERS+1];

   logic signed [OP_W-1:0] ord_ext, abs_ext, x_pre, y_pre;
   logic signed [XY_W-1:0] x_in, y_in;
   logic signed [Z_W-1:0]  z_in;
   logic                   zero_in;
   logic                   abs_neg;

   // left half plane folds over to the right with a half turn preset
   always_comb begin
      ord_ext = {ordinate[AXIS_W-1], ordinate};
      abs_ext = {abscissa[AXIS_W-1], abscissa};
      abs_neg = abscissa[AXIS_W-1];
      x_pre   = abs_neg ? -abs_ext : abs_ext;
      y_pre   = abs_neg ? -ord_ext : ord_ext;
      x_in    = {{(XY_W-OP_W-PRESCALE){x_pre[OP_W-1]}}, x_pre, {PRESCALE{1'b0}}};
      y_in    = {{(XY_W-OP_W-PRESCALE){y_pre[OP_W-1]}}, y_pre, {PRESCALE{1'b0}}};
      if (!abs_neg) begin
         z_in = '0;
      end else if (ordinate[AXIS_W-1]) begin
         z_in = NEG_HALF_TURN;
      end else begin
         z_in = HALF_TURN;
      end
      zero_in = (ordinate == '0) && (abscissa == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
         zero_ff[0] <= zero_in;
      end
   end

   for (genvar i = 0; i < ITERS; i++) begin : g_iter
      logic signed [XY_W-1:0] dx, dy, xi_in, yi_in;
      logic signed [Z_W-1:0]  zi_in;
      logic                   rot_neg;

      assign dx      = y_ff[i] >>> i;
      assign dy      = x_ff[i] >>> i;
      assign rot_neg = ~y_ff[i][XY_W-1];
      assign xi_in   = rot_neg ? x_ff[i] + dx : x_ff[i] - dx;
      assign yi_in   = rot_neg ? y_ff[i] - dy : y_ff[i] + dy;
      assign zi_in   = rot_neg ? z_ff[i] + ATAN_TAB[i] : z_ff[i] - ATAN_TAB[i];

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]    <= xi_in;
            y_ff[i+1]    <= yi_in;
            z_ff[i+1]    <= zi_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // clamp to [0, 360] and round half up in one add; a zero vector gives 180
   logic signed [Z_W-1:0] round_sum, round_shift;
   logic [ANGLE_W-1:0]    angle_ff, angle_in;

   always_comb begin
      round_sum   = z_ff[ITERS] + RND_OFFSET;
      round_shift = round_sum >>> SH;
      priority if (zero_ff[ITERS]) begin
         angle_in = ZERO_CODE;
      end else if (z_ff[ITERS] < NEG_HALF_TURN) begin
         angle_in = '0;
      end else if (z_ff[ITERS] > HALF_TURN) begin
         angle_in = FULL_CODE;
      end else begin
         angle_in = ANGLE_W'(round_shift);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

@@ rtl/core/maa_merge.sv @@
// ----------------------------------------------------------------------------
// maa_merge
// Output register with skid stage for the joined result items.
// ----------------------------------------------------------------------------
module maa_merge
   import maa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_data,
   output logic       advance,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       push, out_load_new, out_load_skid, skid_load;

   // pipeline moves only while the skid stage is free
   assign advance = ~skid_valid_ff;

   always_comb begin
      push          = in_valid && advance;
      out_load_new  = push && (!out_valid_ff || rsp_tready);
      skid_load     = push && out_valid_ff && !rsp_tready;
      out_load_skid = skid_valid_ff && rsp_tready;
      out_valid_in  = out_load_new || out_load_skid || (out_valid_ff && !rsp_tready);
      skid_valid_in = skid_load || (skid_valid_ff && !rsp_tready);
      priority if (out_load_skid) begin
         out_data_in = skid_data_ff;
      end else if (out_load_new) begin
         out_data_in = in_data;
      end else begin
         out_data_in = out_data_ff;
      end
      skid_data_in = skid_load ? in_data : skid_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_data_ff;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (in_valid && advance && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("item arriving at a stalled output was not caught by the skid stage");
`endif

endmodule

@@ rtl/core/magnetometer_axis_angles.sv @@
// ----------------------------------------------------------------------------
// magnetometer_axis_angles
// Rebuilds signed x, y, z from a six-byte sample and computes three plane
// angles in three parallel cordic lanes, merged into one result item.
// ----------------------------------------------------------------------------
// path: an accepted item passes the operand fold stage, 24 cordic steps,
//    the rounding stage and the output register
// throughput: one item per cycle; the pipeline advances as a whole and halts
//    only while the output skid stage is occupied
// reset clears the pipeline valid bits and the output/skid valid flags
module magnetometer_axis_angles
   import maa_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // x_low_byte, x_high_byte, z_low_byte, z_high_byte, y_low_byte, y_high_byte
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // x_value, y_value, z_value, angle_xy_plane, angle_zx_plane, angle_zy_plane, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int ANGLE_MAX  = 360 << ANGLE_FRAC_BITS;
   localparam bit ANGLE_FITS = ANGLE_MAX < (1 << ANGLE_W);

   logic                     advance;
   logic [LANE_STAGES-1:0]   valid_ff, valid_in;
   axes_type                 axes_ff [LANE_STAGES];
   axes_type                 axes_in;
   logic [ANGLE_W-1:0]       ang_xy, ang_zx, ang_zy;
   result_type               merge_in, rsp_data;

   always_comb begin
      axes_in.x_value = $signed(req_tdata[15:0]);
      axes_in.z_value = $signed(req_tdata[31:16]);
      axes_in.y_value = $signed(req_tdata[47:32]);
   end

   assign req_tready = advance;
   assign valid_in   = {valid_ff[LANE_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // axis values ride alongside the lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         axes_ff[0] <= axes_in;
         for (int s = 1; s < LANE_STAGES; s++) begin
            axes_ff[s] <= axes_ff[s-1];
         end
      end
   end

   maa_cordic_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_xy (
      .clock    (clock),
      .advance  (advance),
      .ordinate (axes_in.y_value),
      .abscissa (axes_in.x_value),
      .angle    (ang_xy)
   );

   maa_cordic_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_zx (
      .clock    (clock),
      .advance  (advance),
      .ordinate (axes_in.x_value),
      .abscissa (axes_in.z_value),
      .angle    (ang_zx)
   );

   maa_cordic_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_zy (
      .clock    (clock),
      .advance  (advance),
      .ordinate (axes_in.y_value),
      .abscissa (axes_in.z_value),
      .angle    (ang_zy)
   );

   always_comb begin
      merge_in.pad            = '0;
      merge_in.angle_zy_plane = ang_zy;
      merge_in.angle_zx_plane = ang_zx;
      merge_in.angle_xy_plane = ang_xy;
      merge_in.z_value        = axes_ff[LANE_STAGES-1].z_value;
      merge_in.y_value        = axes_ff[LANE_STAGES-1].y_value;
      merge_in.x_value        = axes_ff[LANE_STAGES-1].x_value;
   end

   maa_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_ff[LANE_STAGES-1]),
      .in_data    (merge_in),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data;

`ifndef ASSERT_OFF
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LANE_STAGES-1] && !advance) |=> valid_ff[LANE_STAGES-1])
      else $error("item at the end of the lanes lost during a stall");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!ANGLE_FITS ||
         ((rsp_data.angle_xy_plane <= ANGLE_MAX) &&
          (rsp_data.angle_zx_plane <= ANGLE_MAX) &&
          (rsp_data.angle_zy_plane <= ANGLE_MAX))))
      else $error("plane angle beyond a full turn");
`endif

endmodule
